// ===== hdl/ccs_pkg.sv =====
`timescale 1ns / 1ps
package ccs_pkg;

	localparam int QW = 32;
	localparam int DIV_STAGES = QW;

	localparam logic [2:0] REG_LEVEL_COUNT = 3'd0;
	localparam logic [2:0] REG_LEVEL_A = 3'd1;

	localparam logic [3:0] CASE_NONE = 4'd0;

	// role codes inside a triangle: first corner, center, next corner
	localparam logic [1:0] ROLE_FIRST = 2'd0;
	localparam logic [1:0] ROLE_CENTER = 2'd1;
	localparam logic [1:0] ROLE_NEXT = 2'd2;

	// indexed by (first, center, next) height signs, each below/at/above as 0/1/2
	localparam logic [3:0] CASE_TAB [27] = '{
		4'd0, 4'd0, 4'd8, 4'd0, 4'd2, 4'd5, 4'd7, 4'd6, 4'd9,
		4'd0, 4'd3, 4'd4, 4'd1, 4'd3, 4'd1, 4'd4, 4'd3, 4'd0,
		4'd9, 4'd6, 4'd7, 4'd5, 4'd2, 4'd0, 4'd8, 4'd0, 4'd0
	};

	// per case {start a, start b, end a, end b} as role codes; a == b means a vertex
	localparam logic [7:0] SEG_ENDS [16] = '{
		8'b0000_0000, 8'b0000_0101, 8'b0101_1010, 8'b1010_0000,
		8'b0000_0110, 8'b0101_1000, 8'b1010_0001, 8'b0001_0110,
		8'b0110_1000, 8'b1000_0001, 8'b0000_0000, 8'b0000_0000,
		8'b0000_0000, 8'b0000_0000, 8'b0000_0000, 8'b0000_0000
	};

	typedef struct packed {
		logic signed [31:0] corner_ll;
		logic signed [31:0] corner_hl;
		logic signed [31:0] corner_hh;
		logic signed [31:0] corner_lh;
		logic signed [31:0] x_low;
		logic signed [31:0] x_high;
		logic signed [31:0] y_low;
		logic signed [31:0] y_high;
	} cell_t;

	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic [1:0] level_index;
		logic last_segment;
	} seg_t;

	typedef struct packed {
		logic [1:0] level;
		logic last;
	} seg_tag_t;

	typedef struct packed {
		logic signed [31:0] xa;
		logic neg;
		logic [35:0] ham;
		logic [31:0] dxm;
		logic [36:0] denm;
	} lane_op_t;

	typedef struct packed {
		logic signed [31:0] xa;
		logic neg;
		logic [36:0] denm;
		logic [63:0] lo;
		logic [35:0] hi;
	} lane_pp_t;

	typedef struct packed {
		logic signed [31:0] xa;
		logic neg;
		logic [36:0] denm;
		logic [36:0] rem;
		logic [QW-1:0] low;
	} lane_div_t;

	typedef struct packed {
		lane_op_t [3:0] lane;
		seg_tag_t tag;
	} op_stage_t;

	typedef struct packed {
		lane_pp_t [3:0] lane;
		seg_tag_t tag;
	} pp_stage_t;

	typedef struct packed {
		lane_div_t [3:0] lane;
		seg_tag_t tag;
	} div_stage_t;

	function automatic logic [1:0] sign_code(logic signed [35:0] h);
		logic [1:0] s;
		if (h < 0)
			s = 2'd0;
		else if (h == 0)
			s = 2'd1;
		else
			s = 2'd2;
		return s;
	endfunction

	function automatic logic [3:0] tri_case(logic [1:0] s0, logic [1:0] s1, logic [1:0] s2);
		logic [4:0] idx;
		idx = 5'(s0) * 5'd9 + 5'(s1) * 5'd3 + 5'(s2);
		return CASE_TAB[idx];
	endfunction

	// vertex number (0 center, 1..4 corners) for a role in triangle tidx
	function automatic logic [2:0] role_vtx(logic [1:0] r, logic [1:0] tidx);
		logic [2:0] v;
		case (r)
			ROLE_FIRST: v = 3'(tidx) + 3'd1;
			ROLE_CENTER: v = 3'd0;
			ROLE_NEXT: v = (tidx == 2'd3) ? 3'd1 : 3'(tidx) + 3'd2;
			default: v = 3'd0;
		endcase
		return v;
	endfunction

	// one restoring step: shift in the next dividend bit, shift out a quotient bit
	function automatic lane_div_t div_step(lane_div_t d);
		lane_div_t r;
		logic [37:0] t;
		r = d;
		t = {d.rem, d.low[QW-1]};
		if (t >= {1'b0, d.denm}) begin
			r.rem = 37'(t - {1'b0, d.denm});
			r.low = {d.low[QW-2:0], 1'b1};
		end else begin
			r.rem = t[36:0];
			r.low = {d.low[QW-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

// ===== hdl/contour_cell_segments_core.sv =====
`timescale 1ns / 1ps
// Contour segments of one grid cell per transaction: each cell is split into four triangles
// around its center; with ascending levels each configured level inside the corner range
// yields up to one segment per triangle, end points interpolated exactly and saturated to
// Q16.16. A cell is taken every cycle while it yields at most one segment and the output
// does not stall; one with more holds the input until the segment issue stage has sent
// them all, one per cycle into the interpolation pipeline unless it stalls. Path: input
// register, case evaluation, operand select, two multiply stages, a 32-step restoring
// divider, one quotient bit per stage. Cells with no segment produce no output transaction.
module contour_cell_segments_core #(
	parameter int MAX_LEVELS = 4
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic cell_valid,
	output logic cell_stall,
	input ccs_pkg::cell_t cell_item,
	output logic seg_valid,
	input logic seg_stall,
	output ccs_pkg::seg_t seg_item
);
	import ccs_pkg::*;

	localparam int SLOTS = 4 * MAX_LEVELS;
	localparam int SW = $clog2(SLOTS);

	logic [2:0] level_count_q;
	logic signed [31:0] level_q [MAX_LEVELS];

	logic s1_valid_q;
	cell_t s1_cell_q;

	logic s2_valid_q;
	logic [SLOTS-1:0] s2_mask_q;
	logic [3:0] s2_case_q [SLOTS];
	logic signed [35:0] s2_h_q [MAX_LEVELS][5];
	logic signed [31:0] s2_px_q [5];
	logic signed [31:0] s2_py_q [5];

	logic v_op_q, v_pp_q;
	op_stage_t op_q;
	pp_stage_t pp_q;
	logic [DIV_STAGES:0] v_div_q;
	div_stage_t div_q [DIV_STAGES+1];
	logic seg_valid_q;
	seg_t seg_q;

	logic adv_out, adv_pp, adv_op, adv_s1, s2_load, s2_emit;
	logic [DIV_STAGES:0] adv_div;

	// case evaluation
	logic signed [31:0] cv [4];
	logic signed [31:0] dmin, dmax, hi_lev;
	logic [2:0] nlev;
	logic gate;
	logic signed [32:0] csum_x, csum_y, cadj_x, cadj_y;
	logic signed [31:0] px_n [5];
	logic signed [31:0] py_n [5];
	logic signed [33:0] dv [4];
	logic signed [35:0] h_n [MAX_LEVELS][5];
	logic [3:0] case_n [SLOTS];
	logic [SLOTS-1:0] mask_n;
	logic use_lev;
	logic [2:0] r0, r2;

	always_comb begin
		cv[0] = s1_cell_q.corner_ll;
		cv[1] = s1_cell_q.corner_hl;
		cv[2] = s1_cell_q.corner_hh;
		cv[3] = s1_cell_q.corner_lh;
		dmin = cv[0];
		dmax = cv[0];
		for (int i = 1; i < 4; i++) begin
			if (cv[i] < dmin) dmin = cv[i];
			if (cv[i] > dmax) dmax = cv[i];
		end
		nlev = (level_count_q > 3'(MAX_LEVELS)) ? 3'(MAX_LEVELS) : level_count_q;
		hi_lev = level_q[0];
		for (int k = 0; k < MAX_LEVELS; k++)
			if (3'(k + 1) == nlev) hi_lev = level_q[k];
		gate = (nlev != 3'd0) && (dmax >= level_q[0]) && (dmin <= hi_lev);

		// center: truncate toward zero
		csum_x = 33'(s1_cell_q.x_low) + 33'(s1_cell_q.x_high);
		csum_y = 33'(s1_cell_q.y_low) + 33'(s1_cell_q.y_high);
		cadj_x = csum_x + $signed({32'd0, csum_x[32]});
		cadj_y = csum_y + $signed({32'd0, csum_y[32]});
		px_n[0] = 32'(cadj_x >>> 1);
		py_n[0] = 32'(cadj_y >>> 1);
		px_n[1] = s1_cell_q.x_low;
		px_n[2] = s1_cell_q.x_high;
		px_n[3] = s1_cell_q.x_high;
		px_n[4] = s1_cell_q.x_low;
		py_n[1] = s1_cell_q.y_low;
		py_n[2] = s1_cell_q.y_low;
		py_n[3] = s1_cell_q.y_high;
		py_n[4] = s1_cell_q.y_high;

		for (int k = 0; k < MAX_LEVELS; k++) begin
			use_lev = gate && (3'(k) < nlev) && (level_q[k] >= dmin) && (level_q[k] <= dmax);
			for (int i = 0; i < 4; i++) begin
				dv[i] = 34'(cv[i]) - 34'(level_q[k]);
				h_n[k][i+1] = {dv[i], 2'b00};
			end
			h_n[k][0] = 36'(dv[0]) + 36'(dv[1]) + 36'(dv[2]) + 36'(dv[3]);
			for (int m = 0; m < 4; m++) begin
				r0 = 3'(m + 1);
				r2 = (m == 3) ? 3'd1 : 3'(m + 2);
				case_n[k*4+m] = tri_case(sign_code(h_n[k][r0]), sign_code(h_n[k][0]),
					sign_code(h_n[k][r2]));
				mask_n[k*4+m] = use_lev && (case_n[k*4+m] != CASE_NONE);
			end
		end
	end

	// segment issue
	logic [SW-1:0] idx;
	logic [SLOTS-1:0] next_mask;
	logic [1:0] lvl, tidx;
	logic [3:0] cur_case;
	logic [7:0] ends;
	logic signed [35:0] hv [5];
	logic [2:0] va, vb;
	logic signed [35:0] ha, hb;
	logic signed [31:0] xa, xb;
	logic signed [32:0] dx;
	logic signed [36:0] den;
	op_stage_t op_n;

	always_comb begin
		idx = '0;
		for (int j = SLOTS - 1; j >= 0; j--)
			if (s2_mask_q[j]) idx = SW'(j);
		next_mask = s2_mask_q & (s2_mask_q - SLOTS'(1));
		lvl = 2'(idx >> 2);
		tidx = idx[1:0];
		cur_case = s2_case_q[idx];
		ends = SEG_ENDS[cur_case];
		for (int v = 0; v < 5; v++)
			hv[v] = s2_h_q[0][v];
		for (int k = 0; k < MAX_LEVELS; k++)
			if (2'(k) == lvl)
				for (int v = 0; v < 5; v++)
					hv[v] = s2_h_q[k][v];
		op_n.tag.level = lvl;
		op_n.tag.last = (next_mask == '0);
		for (int l = 0; l < 4; l++) begin
			// lanes: start x, start y, end x, end y
			if (l < 2) begin
				va = role_vtx(ends[7:6], tidx);
				vb = role_vtx(ends[5:4], tidx);
			end else begin
				va = role_vtx(ends[3:2], tidx);
				vb = role_vtx(ends[1:0], tidx);
			end
			ha = hv[va];
			hb = hv[vb];
			xa = (l % 2 == 0) ? s2_px_q[va] : s2_py_q[va];
			xb = (l % 2 == 0) ? s2_px_q[vb] : s2_py_q[vb];
			dx = 33'(xb) - 33'(xa);
			den = 37'(hb) - 37'(ha);
			op_n.lane[l].xa = xa;
			op_n.lane[l].neg = ((ha > 0) ^ dx[32]) ^ den[36];
			op_n.lane[l].ham = ha[35] ? 36'(-ha) : 36'(ha);
			op_n.lane[l].dxm = dx[32] ? 32'(-dx) : 32'(dx);
			op_n.lane[l].denm = den[36] ? 37'(-den) : 37'(den);
			// vertex ends and a zero denominator give no offset
			if (den == 0) begin
				op_n.lane[l].ham = '0;
				op_n.lane[l].denm = 37'd1;
			end
		end
	end

	// stage advance: a stage loads when it is empty or its successor loads
	always_comb begin
		adv_out = !seg_valid_q || !seg_stall;
		adv_div[DIV_STAGES] = !v_div_q[DIV_STAGES] || adv_out;
		for (int i = DIV_STAGES - 1; i >= 0; i--)
			adv_div[i] = !v_div_q[i] || adv_div[i+1];
		adv_pp = !v_pp_q || adv_div[0];
		adv_op = !v_op_q || adv_pp;
		s2_emit = s2_valid_q && adv_op;
		s2_load = !s2_valid_q || (s2_emit && (next_mask == '0));
		adv_s1 = !s1_valid_q || s2_load;
	end

	assign cell_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_count_q <= 3'd1;
			for (int k = 0; k < MAX_LEVELS; k++)
				level_q[k] <= '0;
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
			s2_mask_q <= '0;
			v_op_q <= 1'b0;
			v_pp_q <= 1'b0;
			v_div_q <= '0;
			seg_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_LEVEL_COUNT)
					level_count_q <= cfg_data[2:0];
				for (int k = 0; k < MAX_LEVELS; k++)
					if (cfg_index == REG_LEVEL_A + 3'(k))
						level_q[k] <= cfg_data;
			end
			if (adv_s1)
				s1_valid_q <= cell_valid;
			// drop cells that yield no segment here
			if (s2_load) begin
				s2_valid_q <= s1_valid_q && (mask_n != '0);
				s2_mask_q <= mask_n;
			end else if (s2_emit) begin
				s2_mask_q <= next_mask;
			end
			if (adv_op)
				v_op_q <= s2_valid_q;
			if (adv_pp)
				v_pp_q <= v_op_q;
			if (adv_div[0])
				v_div_q[0] <= v_pp_q;
			for (int i = 1; i <= DIV_STAGES; i++)
				if (adv_div[i])
					v_div_q[i] <= v_div_q[i-1];
			if (adv_out)
				seg_valid_q <= v_div_q[DIV_STAGES];
		end
	end

	logic signed [33:0] res [4];
	logic signed [31:0] sat [4];
	logic [67:0] prod [4];
	div_stage_t div0_n;

	always_comb begin
		div0_n.tag = pp_q.tag;
		for (int l = 0; l < 4; l++) begin
			prod[l] = {4'd0, pp_q.lane[l].lo} + {pp_q.lane[l].hi, 32'd0};
			div0_n.lane[l].xa = pp_q.lane[l].xa;
			div0_n.lane[l].neg = pp_q.lane[l].neg;
			div0_n.lane[l].denm = pp_q.lane[l].denm;
			div0_n.lane[l].rem = {1'b0, prod[l][67:32]};
			div0_n.lane[l].low = prod[l][31:0];
		end
		for (int l = 0; l < 4; l++) begin
			res[l] = div_q[DIV_STAGES].lane[l].neg ?
				34'(div_q[DIV_STAGES].lane[l].xa) - $signed({2'b00, div_q[DIV_STAGES].lane[l].low}) :
				34'(div_q[DIV_STAGES].lane[l].xa) + $signed({2'b00, div_q[DIV_STAGES].lane[l].low});
			if (res[l][33:31] == 3'b000 || res[l][33:31] == 3'b111)
				sat[l] = res[l][31:0];
			else
				sat[l] = res[l][33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
	end

	always_ff @(posedge clk) begin
		if (cell_valid && adv_s1)
			s1_cell_q <= cell_item;
		if (s2_load) begin
			s2_case_q <= case_n;
			s2_h_q <= h_n;
			s2_px_q <= px_n;
			s2_py_q <= py_n;
		end
		if (adv_op)
			op_q <= op_n;
		if (adv_pp) begin
			pp_q.tag <= op_q.tag;
			for (int l = 0; l < 4; l++) begin
				pp_q.lane[l].xa <= op_q.lane[l].xa;
				pp_q.lane[l].neg <= op_q.lane[l].neg;
				pp_q.lane[l].denm <= op_q.lane[l].denm;
				pp_q.lane[l].lo <= 64'(op_q.lane[l].ham[31:0]) * 64'(op_q.lane[l].dxm);
				pp_q.lane[l].hi <= 36'(op_q.lane[l].ham[35:32]) * 36'(op_q.lane[l].dxm);
			end
		end
		if (adv_div[0])
			div_q[0] <= div0_n;
		for (int i = 1; i <= DIV_STAGES; i++)
			if (adv_div[i]) begin
				div_q[i].tag <= div_q[i-1].tag;
				for (int l = 0; l < 4; l++)
					div_q[i].lane[l] <= div_step(div_q[i-1].lane[l]);
			end
		if (adv_out) begin
			seg_q.start_x <= sat[0];
			seg_q.start_y <= sat[1];
			seg_q.end_x <= sat[2];
			seg_q.end_y <= sat[3];
			seg_q.level_index <= div_q[DIV_STAGES].tag.level;
			seg_q.last_segment <= div_q[DIV_STAGES].tag.last;
		end
	end

	assign seg_valid = seg_valid_q;
	assign seg_item = seg_q;

	a_s2_mask: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q |-> (s2_mask_q != '0))
		else $error("issue stage holds a cell with no pending segment");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_emit && (next_mask != '0)) |=> (s2_valid_q && (s2_mask_q == $past(next_mask))))
		else $error("issue stage lost pending segments");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		v_div_q[DIV_STAGES] |->
			(div_q[DIV_STAGES].lane[0].rem < div_q[DIV_STAGES].lane[0].denm))
		else $error("divider remainder not below denominator");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		cell_stall |-> (s1_valid_q && s2_valid_q))
		else $error("input stalled with room in the front stages");

endmodule

// ===== tb/contour_checker.sv =====
`timescale 1ns / 1ps
module contour_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic cell_valid,
	input logic cell_stall,
	input ccs_pkg::cell_t cell_item,
	input logic seg_valid,
	input logic seg_stall,
	input ccs_pkg::seg_t seg_item,
	output int failures,
	output int pending,
	output int segs_seen
);
	import ccs_pkg::*;

	// triangle case by sign of (first, center, next) heights, each -1/0/+1 offset by one
	localparam logic [3:0] TRI_CASE [27] = '{
		4'd0, 4'd0, 4'd8, 4'd0, 4'd2, 4'd5, 4'd7, 4'd6, 4'd9,
		4'd0, 4'd3, 4'd4, 4'd1, 4'd3, 4'd1, 4'd4, 4'd3, 4'd0,
		4'd9, 4'd6, 4'd7, 4'd5, 4'd2, 4'd0, 4'd8, 4'd0, 4'd0
	};
	// per case: start role pair, end role pair (0 first corner, 1 center, 2 next corner)
	localparam int END_ROLES [10][4] = '{
		'{0, 0, 0, 0}, '{0, 0, 1, 1}, '{1, 1, 2, 2}, '{2, 2, 0, 0}, '{0, 0, 1, 2},
		'{1, 1, 2, 0}, '{2, 2, 0, 1}, '{0, 1, 1, 2}, '{1, 2, 2, 0}, '{2, 0, 0, 1}
	};

	logic [2:0] level_count;
	longint level_val [4];
	seg_t expected_segs [$];

	function automatic int sgn(longint v);
		return v > 0 ? 1 : (v < 0 ? -1 : 0);
	endfunction

	function automatic logic [63:0] mag(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	// edge point from a to b where the height crosses zero, truncated toward zero
	function automatic longint edge_point(longint ha, longint xa, longint hb, longint xb);
		logic [127:0] prod;
		logic [127:0] quo;
		longint num, den;
		num = xb - xa;
		den = hb - ha;
		prod = {64'd0, mag(-ha)} * {64'd0, mag(num)};
		quo = (den == 0) ? 128'd0 : prod / {64'd0, mag(den)};
		if (sgn(-ha) * sgn(num) * sgn(den) < 0)
			return xa - longint'(quo[63:0]);
		return xa + longint'(quo[63:0]);
	endfunction

	function automatic void predict_cell(cell_t c);
		longint cv [4];
		longint px [5];
		longint py [5];
		longint ht [5];
		longint lo, hi, z;
		longint pt [4];
		seg_t segs [$];
		seg_t s;
		int nlev, role [3], cs, a, b;
		cv[0] = c.corner_ll;
		cv[1] = c.corner_hl;
		cv[2] = c.corner_hh;
		cv[3] = c.corner_lh;
		nlev = (level_count > 4) ? 4 : level_count;
		if (nlev == 0)
			return;
		lo = cv[0];
		hi = cv[0];
		for (int i = 1; i < 4; i++) begin
			if (cv[i] < lo) lo = cv[i];
			if (cv[i] > hi) hi = cv[i];
		end
		if (!(hi >= level_val[0] && lo <= level_val[nlev - 1]))
			return;
		px[0] = (longint'(c.x_low) + longint'(c.x_high)) / 2;
		py[0] = (longint'(c.y_low) + longint'(c.y_high)) / 2;
		px[1] = c.x_low;  py[1] = c.y_low;
		px[2] = c.x_high; py[2] = c.y_low;
		px[3] = c.x_high; py[3] = c.y_high;
		px[4] = c.x_low;  py[4] = c.y_high;
		for (int k = 0; k < nlev; k++) begin
			z = level_val[k];
			if (!(z >= lo && z <= hi))
				continue;
			ht[0] = 0;
			for (int i = 0; i < 4; i++) begin
				ht[0] += cv[i] - z;
				ht[i + 1] = (cv[i] - z) * 4;
			end
			for (int m = 1; m <= 4; m++) begin
				role[0] = m;
				role[1] = 0;
				role[2] = (m == 4) ? 1 : m + 1;
				cs = TRI_CASE[(sgn(ht[role[0]]) + 1) * 9 + (sgn(ht[role[1]]) + 1) * 3
					+ sgn(ht[role[2]]) + 1];
				if (cs == CASE_NONE || segs.size() >= 16)
					continue;
				for (int e = 0; e < 2; e++) begin
					a = role[END_ROLES[cs][2 * e]];
					b = role[END_ROLES[cs][2 * e + 1]];
					if (a == b) begin
						pt[2 * e] = px[a];
						pt[2 * e + 1] = py[a];
					end else begin
						pt[2 * e] = edge_point(ht[a], px[a], ht[b], px[b]);
						pt[2 * e + 1] = edge_point(ht[a], py[a], ht[b], py[b]);
					end
				end
				s.start_x = clamp32(pt[0]);
				s.start_y = clamp32(pt[1]);
				s.end_x = clamp32(pt[2]);
				s.end_y = clamp32(pt[3]);
				s.level_index = 2'(k);
				s.last_segment = 1'b0;
				segs = {segs, s};
			end
		end
		if (segs.size() > 0)
			segs[segs.size() - 1].last_segment = 1'b1;
		expected_segs = {expected_segs, segs};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_count <= 3'd1;
			for (int i = 0; i < 4; i++)
				level_val[i] <= 0;
		end else if (cfg_we) begin
			if (cfg_index == REG_LEVEL_COUNT)
				level_count <= cfg_data[2:0];
			else if (cfg_index >= REG_LEVEL_A && cfg_index <= REG_LEVEL_A + 3'd3)
				level_val[cfg_index - REG_LEVEL_A] <= longint'(signed'(cfg_data));
		end
	end

	always @(posedge clk) begin
		seg_t want;
		if (!arst_n) begin
			failures = 0;
			segs_seen = 0;
		end else begin
			if (cell_valid && !cell_stall)
				predict_cell(cell_item);
			if (seg_valid && !seg_stall) begin
				segs_seen++;
				if (expected_segs.size() == 0) begin
					$error("segment with nothing expected: %p", seg_item);
					failures++;
				end else begin
					want = expected_segs.pop_front();
					if (seg_item.start_x !== want.start_x) begin
						$error("start_x: expected %0d, got %0d", want.start_x,
							seg_item.start_x);
						failures++;
					end
					if (seg_item.start_y !== want.start_y) begin
						$error("start_y: expected %0d, got %0d", want.start_y,
							seg_item.start_y);
						failures++;
					end
					if (seg_item.end_x !== want.end_x) begin
						$error("end_x: expected %0d, got %0d", want.end_x, seg_item.end_x);
						failures++;
					end
					if (seg_item.end_y !== want.end_y) begin
						$error("end_y: expected %0d, got %0d", want.end_y, seg_item.end_y);
						failures++;
					end
					if (seg_item.level_index !== want.level_index) begin
						$error("level_index: expected %0d, got %0d", want.level_index,
							seg_item.level_index);
						failures++;
					end
					if (seg_item.last_segment !== want.last_segment) begin
						$error("last_segment: expected %0d, got %0d", want.last_segment,
							seg_item.last_segment);
						failures++;
					end
				end
			end
		end
		pending = expected_segs.size();
	end
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import ccs_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;
	localparam int Q1 = 65536;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = REG_LEVEL_COUNT;
	logic [31:0] cfg_data = '0;
	logic cell_valid = 1'b0;
	logic cell_stall;
	cell_t cell_item = '0;
	logic seg_valid;
	logic seg_stall = 1'b0;
	seg_t seg_item;

	int failures, pending, segs_seen;
	int cells_sent = 0;
	int idle_cycles = 0;
	int level_copy [4] = '{0, 0, 0, 0};
	int stall_left = 0;

	always #10 clk = ~clk;

	contour_cell_segments_core DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cell_valid(cell_valid), .cell_stall(cell_stall), .cell_item(cell_item),
		.seg_valid(seg_valid), .seg_stall(seg_stall), .seg_item(seg_item)
	);

	contour_checker scoreboard (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cell_valid(cell_valid), .cell_stall(cell_stall), .cell_item(cell_item),
		.seg_valid(seg_valid), .seg_stall(seg_stall), .seg_item(seg_item),
		.failures(failures), .pending(pending), .segs_seen(segs_seen)
	);

	// receiver back-pressure: mostly short bursts, a few long holds, free stretches between
	always @(posedge clk) begin
		int r;
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				seg_stall <= 1'b0;
				stall_left <= $urandom_range(0, 30);
			end else if (r < 90) begin
				seg_stall <= 1'b1;
				stall_left <= $urandom_range(0, 3);
			end else begin
				seg_stall <= 1'b1;
				stall_left <= $urandom_range(10, 50);
			end
		end
	end

	always @(posedge clk) begin
		if ((cell_valid && !cell_stall) || (seg_valid && !seg_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx != REG_LEVEL_COUNT)
			level_copy[idx - REG_LEVEL_A] = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// drop valid, wait for every segment, then cover cells still inside that give none
	task automatic drain();
		cell_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (45) @(posedge clk);
	endtask

	task automatic set_levels(int cnt, int a, int b, int c, int d);
		drain();
		write_reg(REG_LEVEL_COUNT, 32'(cnt));
		write_reg(REG_LEVEL_A, a);
		write_reg(REG_LEVEL_A + 3'd1, b);
		write_reg(REG_LEVEL_A + 3'd2, c);
		write_reg(REG_LEVEL_A + 3'd3, d);
	endtask

	task automatic send_cell(cell_t c, bit hold_gap);
		int gap, r;
		bit taken;
		cell_valid <= 1'b1;
		cell_item <= c;
		do begin
			@(negedge clk);
			taken = !cell_stall;
			@(posedge clk);
		end while (!taken);
		cells_sent++;
		r = $urandom_range(0, 99);
		gap = (!hold_gap || r < 50) ? 0 : (r < 88 ? $urandom_range(1, 3)
			: $urandom_range(10, 40));
		if (gap > 0) begin
			cell_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] pick_height(int mode);
		int r;
		r = $urandom_range(0, 9);
		if (mode == 1)
			return $urandom;
		if (mode == 2) begin
			case (r % 5)
				0: return 32'h80000000;
				1: return 32'h7fffffff;
				2: return 32'h0;
				3: return 32'hffffffff;
				default: return level_copy[$urandom_range(0, 3)];
			endcase
		end
		if (r < 2)
			return level_copy[$urandom_range(0, 3)];
		return level_copy[$urandom_range(0, 3)] + $urandom_range(0, 6 * Q1) - 3 * Q1;
	endfunction

	function automatic logic [31:0] pick_coord(int mode);
		if (mode == 1)
			return $urandom;
		if (mode == 2)
			return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
		return $urandom_range(0, 1 << 22) - (1 << 21);
	endfunction

	function automatic cell_t random_cell();
		cell_t c;
		int r, mode;
		r = $urandom_range(0, 99);
		mode = (r < 65) ? 0 : (r < 85 ? 1 : 2);
		c.corner_ll = pick_height(mode);
		c.corner_hl = pick_height(mode);
		c.corner_hh = pick_height(mode);
		c.corner_lh = pick_height(mode);
		c.x_low = pick_coord(mode);
		c.y_low = pick_coord(mode);
		if (mode == 0) begin
			c.x_high = c.x_low + $urandom_range(1, 4 * Q1);
			c.y_high = c.y_low + $urandom_range(1, 4 * Q1);
		end else begin
			c.x_high = pick_coord(mode);
			c.y_high = pick_coord(mode);
		end
		return c;
	endfunction

	function automatic cell_t make_cell(int ll, int hl, int hh, int lh,
		int xl, int xh, int yl, int yh);
		cell_t c;
		c = '{ll, hl, hh, lh, xl, xh, yl, yh};
		return c;
	endfunction

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++)
			send_cell(random_cell(), 1'b1);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset levels: one level at zero
		send_cell(make_cell(0, 0, 0, 0, 0, Q1, 0, Q1), 1'b0);
		send_cell(make_cell(Q1, -Q1, Q1, -Q1, 0, Q1, 0, Q1), 1'b0);
		send_cell(make_cell(-Q1, -2 * Q1, -Q1, -3 * Q1, 0, Q1, 0, Q1), 1'b0);
		send_cell(make_cell(Q1, 2 * Q1, 3 * Q1, Q1, 0, Q1, 0, Q1), 1'b0);
		send_cell(make_cell(0, Q1, 2 * Q1, -Q1, -Q1, Q1, -Q1, Q1), 1'b0);
		send_cell(make_cell(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff), 1'b0);
		send_cell(make_cell(32'h80000000, 32'h7fffffff, 0, 32'hffffffff,
			32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000), 1'b1);
		send_cell(make_cell(-Q1, Q1, 0, 0, 32'h7fff0000, 32'h7fffffff, 5, 5), 1'b1);
		send_cell(make_cell(Q1, 0, -Q1, 0, 3, -7, -9, 11), 1'b1);
		random_phase(50);

		// four ascending levels; cells spanning all four levels, then flat cells below and above them
		set_levels(4, -2 * Q1, -Q1, Q1, 2 * Q1);
		send_cell(make_cell(-3 * Q1, -Q1, 3 * Q1, Q1, 0, 2 * Q1, 0, 2 * Q1), 1'b0);
		send_cell(make_cell(-2 * Q1, 2 * Q1, -2 * Q1, 2 * Q1, 0, Q1, 0, Q1), 1'b0);
		send_cell(make_cell(-5 * Q1, -5 * Q1, -5 * Q1, -5 * Q1, 0, Q1, 0, Q1), 1'b0);
		send_cell(make_cell(5 * Q1, 5 * Q1, 5 * Q1, 5 * Q1, 0, Q1, 0, Q1), 1'b0);
		random_phase(50);

		// sender holds until the pipeline is empty, then resumes
		drain();
		random_phase(20);

		// no level in use
		set_levels(0, -Q1, 0, Q1, 2 * Q1);
		send_cell(make_cell(-Q1, Q1, 0, 2 * Q1, 0, Q1, 0, Q1), 1'b0);
		random_phase(20);

		// count above the maximum, extreme levels
		set_levels(7, 32'h80000000, -1, 0, 32'h7fffffff);
		send_cell(make_cell(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff), 1'b0);
		send_cell(make_cell(-1, 0, 1, -1, 0, Q1, 0, Q1), 1'b0);
		random_phase(50);

		// two levels out of order
		set_levels(2, 3 * Q1, -2 * Q1, 0, 0);
		send_cell(make_cell(-3 * Q1, 4 * Q1, 0, Q1, 0, Q1, 0, Q1), 1'b0);
		random_phase(50);

		// three levels
		set_levels(3, -Q1, 0, Q1 / 2, 32'h7fffffff);
		random_phase(53);

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d cells and %0d segments over six level settings,", cells_sent,
			segs_seen);
		$display("including zero, out-of-range and extreme level counts and values");
		if (failures == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
